/* rtl/oas_pkg.sv */
// ----------------------------------------------------------------------------
// oas_pkg
// Shared types, codes and reset constants of the obstacle-avoidance sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package oas_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned DistW  = 16;
  localparam int unsigned SpeedW = 7;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [DistW-1:0]  EnterThresholdRst = DistW'(200);
  localparam logic [DistW-1:0]  ExitThresholdRst  = DistW'(250);
  localparam logic [TimeW-1:0]  ReverseTimeRst    = TimeW'(400);
  localparam logic [TimeW-1:0]  TurnTimeRst       = TimeW'(500);
  localparam logic [TimeW-1:0]  CooldownTimeRst   = TimeW'(1200);
  localparam logic [SpeedW-1:0] DriveSpeedRst     = SpeedW'(40);
  localparam logic [SpeedW-1:0] SpeedMax          = SpeedW'(100);

  typedef enum logic [CmdW-1:0] {
    CMD_KEEP    = 2'd0,
    CMD_FORWARD = 2'd1,
    CMD_REVERSE = 2'd2,
    CMD_TURN    = 2'd3
  } drive_cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENTER_THRESHOLD = 3'd0,
    CFG_EXIT_THRESHOLD  = 3'd1,
    CFG_REVERSE_TIME    = 3'd2,
    CFG_TURN_TIME       = 3'd3,
    CFG_COOLDOWN_TIME   = 3'd4,
    CFG_DRIVE_SPEED     = 3'd5
  } cfg_idx_e;

  localparam logic ModeCruise   = 1'b0;
  localparam logic ModeAvoid    = 1'b1;
  localparam logic PhaseReverse = 1'b0;
  localparam logic PhaseTurn    = 1'b1;

  typedef struct packed {
    logic [DistW-1:0]  enter_threshold;
    logic [DistW-1:0]  exit_threshold;
    logic [TimeW-1:0]  reverse_time;
    logic [TimeW-1:0]  turn_time;
    logic [TimeW-1:0]  cooldown_time;
    logic [SpeedW-1:0] drive_speed;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             distance_valid;
    logic [DistW-1:0] distance;
  } in_item_t;

  typedef struct packed {
    logic [CmdW-1:0]   drive_cmd;
    logic [SpeedW-1:0] speed;
    logic              mode;
    logic              phase;
    logic              mode_changed;
    logic              armed;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/oas_if.sv */
// ----------------------------------------------------------------------------
// oas_if
// Valid/ready channel interfaces: input tick, result and config write.
// ----------------------------------------------------------------------------
`default_nettype none

interface oas_in_if import oas_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TimeW-1:0] now_ms;
  logic             distance_valid;
  logic [DistW-1:0] distance;

  modport source (output valid, now_ms, distance_valid, distance, input ready);
  modport sink   (input valid, now_ms, distance_valid, distance, output ready);
endinterface

interface oas_out_if import oas_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   drive_cmd;
  logic [SpeedW-1:0] speed;
  logic              mode;
  logic              phase;
  logic              mode_changed;
  logic              armed;

  modport source (output valid, drive_cmd, speed, mode, phase, mode_changed, armed,
                  input ready);
  modport sink   (input valid, drive_cmd, speed, mode, phase, mode_changed, armed,
                  output ready);
endinterface

interface oas_cfg_if import oas_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/oas_cfg_regs.sv */
// ----------------------------------------------------------------------------
// oas_cfg_regs
// Configuration register file, written by index; unknown indexes ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module oas_cfg_regs import oas_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_en_i,
  input  wire logic [CfgIdxW-1:0]  wr_idx_i,
  input  wire logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_idx_i)
        CFG_ENTER_THRESHOLD: cfg_d.enter_threshold = wr_data_i[DistW-1:0];
        CFG_EXIT_THRESHOLD:  cfg_d.exit_threshold  = wr_data_i[DistW-1:0];
        CFG_REVERSE_TIME:    cfg_d.reverse_time    = wr_data_i[TimeW-1:0];
        CFG_TURN_TIME:       cfg_d.turn_time       = wr_data_i[TimeW-1:0];
        CFG_COOLDOWN_TIME:   cfg_d.cooldown_time   = wr_data_i[TimeW-1:0];
        CFG_DRIVE_SPEED:     cfg_d.drive_speed     = wr_data_i[SpeedW-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enter_threshold <= EnterThresholdRst;
      cfg_q.exit_threshold  <= ExitThresholdRst;
      cfg_q.reverse_time    <= ReverseTimeRst;
      cfg_q.turn_time       <= TurnTimeRst;
      cfg_q.cooldown_time   <= CooldownTimeRst;
      cfg_q.drive_speed     <= DriveSpeedRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/oas_seq.sv */
// ----------------------------------------------------------------------------
// oas_seq
// Sequencer state and the single-pass step logic for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module oas_seq import oas_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t res_o
);

  logic             mode_q, mode_d;
  logic             phase_q, phase_d;
  logic             armed_q, armed_d;
  logic [TimeW-1:0] phase_start_q, phase_start_d;
  logic [TimeW-1:0] cooldown_end_q, cooldown_end_d;

  logic [TimeW-1:0]  elapsed;
  logic [SpeedW-1:0] speed_sat;
  drive_cmd_e        cmd;
  logic              changed;

  assign elapsed   = item_i.now_ms - phase_start_q;  // wraps mod 2^32
  assign speed_sat = (cfg_i.drive_speed > SpeedMax) ? SpeedMax : cfg_i.drive_speed;

  always_comb begin
    mode_d         = mode_q;
    phase_d        = phase_q;
    armed_d        = armed_q;
    phase_start_d  = phase_start_q;
    cooldown_end_d = cooldown_end_q;
    cmd            = CMD_KEEP;
    changed        = 1'b0;

    if (mode_q == ModeCruise) begin
      cmd = CMD_FORWARD;
      // plain unsigned cooldown compare, no wrap handling
      if (item_i.distance_valid && (item_i.now_ms >= cooldown_end_q)) begin
        if (!armed_q) begin
          if (item_i.distance > cfg_i.exit_threshold) armed_d = 1'b1;
        end else if (item_i.distance <= cfg_i.enter_threshold) begin
          phase_start_d = item_i.now_ms;
          phase_d       = PhaseReverse;
          armed_d       = 1'b0;
          mode_d        = ModeAvoid;
          changed       = 1'b1;
          cmd           = CMD_REVERSE;
        end
      end
    end else if (phase_q == PhaseReverse) begin
      if (elapsed >= cfg_i.reverse_time) begin
        phase_d       = PhaseTurn;
        phase_start_d = item_i.now_ms;
        cmd           = CMD_TURN;
      end
    end else if (elapsed >= cfg_i.turn_time) begin
      cooldown_end_d = item_i.now_ms + cfg_i.cooldown_time;
      mode_d         = ModeCruise;
      changed        = 1'b1;
      cmd            = CMD_FORWARD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= ModeCruise;
      phase_q        <= PhaseReverse;
      armed_q        <= 1'b1;
      phase_start_q  <= '0;
      cooldown_end_q <= '0;
    end else if (step_i) begin
      mode_q         <= mode_d;
      phase_q        <= phase_d;
      armed_q        <= armed_d;
      phase_start_q  <= phase_start_d;
      cooldown_end_q <= cooldown_end_d;
    end
  end

  always_comb begin
    res_o.drive_cmd    = cmd;
    res_o.speed        = (cmd == CMD_KEEP) ? '0 : speed_sat;
    res_o.mode         = mode_d;
    res_o.phase        = phase_d;
    res_o.mode_changed = changed;
    res_o.armed        = armed_d;
  end

endmodule

`default_nettype wire

/* rtl/obstacle_avoid_sequencer_top.sv */
// Input transaction to result valid: input reg, then result reg.
// One tick per cycle if not stalled; the state feedback closes in the step stage.
// A stalled output holds both stages; the input reg frees as the result reg drains.
// Reset (rst_ni, async, active low): pipeline empty, state cruising/reverse/armed,
// config registers at their default values. No clearing pass.
// ----------------------------------------------------------------------------
// obstacle_avoid_sequencer_top
// Top level: input register, step logic with state, result register, config.
// ----------------------------------------------------------------------------
`default_nettype none

module obstacle_avoid_sequencer_top import oas_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  oas_cfg_if.sink    cfg_chan,
  oas_in_if.sink     in_chan,
  oas_out_if.source  out_chan
);

  // --------------------------------------------------------------------------
  // Config channel: always ready. Writes must arrive only while idle; the
  // block does not enforce it and has no interlock against in-flight ticks.
  // --------------------------------------------------------------------------
  cfg_t cfg;

  assign cfg_chan.ready = 1'b1;

  oas_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_chan.valid),
    .wr_idx_i  (cfg_chan.index),
    .wr_data_i (cfg_chan.data),
    .cfg_o     (cfg)
  );

  // --------------------------------------------------------------------------
  // Pipeline control. The step stage advances whenever the result register
  // is empty or being drained this cycle; the input register can then take
  // a new transaction in the same cycle.
  // --------------------------------------------------------------------------
  logic      in_vld_q, in_vld_d;
  in_item_t  in_q;
  logic      out_vld_q, out_vld_d;
  out_item_t out_q;
  out_item_t res;
  logic      advance;
  logic      in_take;
  logic      step;

  assign advance  = !out_vld_q || out_chan.ready;
  assign in_take  = in_chan.valid && in_chan.ready;
  assign step     = in_vld_q && advance;

  assign in_chan.ready = !in_vld_q || advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_chan.ready) in_vld_d = in_chan.valid;
    out_vld_d = out_vld_q;
    if (advance) out_vld_d = in_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.now_ms         <= in_chan.now_ms;
      in_q.distance_valid <= in_chan.distance_valid;
      in_q.distance       <= in_chan.distance;
    end
    if (step) out_q <= res;
  end

  // --------------------------------------------------------------------------
  // Step logic: mode/phase sequencing, cooldown and arm tracking.
  // State commits only on a step, so a stalled tick is evaluated again
  // against the same state.
  // --------------------------------------------------------------------------
  oas_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // --------------------------------------------------------------------------
  // Result channel
  // --------------------------------------------------------------------------
  assign out_chan.valid        = out_vld_q;
  assign out_chan.drive_cmd    = out_q.drive_cmd;
  assign out_chan.speed        = out_q.speed;
  assign out_chan.mode         = out_q.mode;
  assign out_chan.phase        = out_q.phase;
  assign out_chan.mode_changed = out_q.mode_changed;
  assign out_chan.armed        = out_q.armed;

endmodule

`default_nettype wire
